[sv/vpi_pkg.sv]
package vpi_pkg;

  // Field and datapath widths
  localparam int DATA_W     = 32;                   // Q16.16 positions, forces, velocities
  localparam int DRAG_W     = 17;                   // unsigned Q1.16 drag coefficient
  localparam int DT_W       = 16;                   // unsigned Q0.16 step length
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 4 * DATA_W + DT_W;    // 144 bits, whole bytes
  localparam int OUT_DATA_W = 4 * DATA_W;           // 128 bits
  localparam int CFG_ADDR_W = 1;

  // Shared divider: signed dividend up to +/-2^48, unsigned 32-bit divisor
  localparam int DIV_W     = 50;
  localparam int DIV_MAG_W = DIV_W - 1;
  localparam int DEN_W     = 32;
  localparam int CNT_W     = $clog2(DIV_MAG_W);

  // Shared multiplier: 33 x 33 signed
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [DATA_W-1:0] MASS_RST = 32'd65536;
  localparam logic [DRAG_W-1:0] DRAG_RST = 17'd32768;

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2147483647);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_FORCE  = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_SETPOS = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MASS = 1'b0,
    REG_DRAG = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FORCE,
    ST_DT2,
    ST_DT2W,
    ST_VEL,
    ST_DMUL,
    ST_DFRC,
    ST_DDIV,
    ST_IMUL,
    ST_IDIV,
    ST_AMUL,
    ST_SUM,
    ST_COMMIT,
    ST_OVEL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;   // signed dividend
    logic [DEN_W-1:0]  den;   // unsigned divisor
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  q;     // signed quotient, truncated toward zero
  } div_rsp_t;

  typedef struct packed {
    logic              en;
    logic [MUL_W-1:0]  a;     // signed operand
    logic [MUL_W-1:0]  b;     // signed operand
  } mul_req_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > SAT_HI) begin
      sat32 = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      sat32 = SAT_LO[DATA_W-1:0];
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  // Arithmetic right shift that rounds toward zero
  function automatic logic signed [PROD_W-1:0] trunc_shr(input logic signed [PROD_W-1:0] v,
                                                         input int unsigned sh);
    logic signed [PROD_W-1:0] bias;
    bias = (PROD_W'(1) <<< sh) - PROD_W'(1);
    if (v < 0) begin
      trunc_shr = (v + bias) >>> sh;
    end else begin
      trunc_shr = v >>> sh;
    end
  endfunction

endpackage

[sv/vpi_div.sv]
module vpi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vpi_pkg::div_req_t  req,
  output vpi_pkg::div_rsp_t  rsp
);
  import vpi_pkg::*;

  logic                    busy_r;
  logic                    fin_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic                    zero_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem_r;
  logic [DIV_MAG_W-1:0]    quo_r;
  logic [DIV_W-1:0]        q_r;

  logic signed [DIV_W-1:0] num_s;
  logic [DIV_W-1:0]        mag;
  logic [DEN_W+1:0]        trial;
  logic                    fits;

  // Magnitude of the dividend, taken on start
  assign num_s = $signed(req.num);
  assign mag   = (num_s < 0) ? DIV_W'(-num_s) : DIV_W'(num_s);

  // One restoring step: shift in the next dividend bit, try to subtract
  assign trial = {1'b0, rem_r, quo_r[DIV_MAG_W-1]} - {2'b00, den_r};
  assign fits  = ~trial[DEN_W+1];

  // Control: one quotient bit a cycle, then a sign-fixing step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && fin_r;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r && fin_r) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_MAG_W - 1)) begin
          fin_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, shifting quotient, signed result
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      neg_r  <= num_s < 0;
      zero_r <= (mag == '0);
      den_r  <= req.den;
      rem_r  <= '0;
      quo_r  <= mag[DIV_MAG_W-1:0];
    end else if (busy_r && fin_r) begin
      if (zero_r) begin
        q_r <= '0;
      end else if (neg_r) begin
        q_r <= DIV_W'(0) - {1'b0, quo_r};
      end else begin
        q_r <= {1'b0, quo_r};
      end
    end else if (busy_r) begin
      rem_r <= fits ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], quo_r[DIV_MAG_W-1]};
      quo_r <= {quo_r[DIV_MAG_W-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

[sv/vpi_mul.sv]
module vpi_mul (
  input  logic                       clk,
  input  vpi_pkg::mul_req_t          req,
  output logic [vpi_pkg::PROD_W-1:0] prod
);
  import vpi_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  // Register the product; hold it until the next issue
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= $signed(req.a) * $signed(req.b);
    end
  end

  assign prod = prod_r;

endmodule

[sv/verlet_point_integrator_core.sv]
// Channel | Ports                          | Beat contents (lowest bits first)
// input   | in_tvalid/in_tready/in_tdata   | force_x, force_y, new_x, new_y, time_step
//         | in_tuser                       | cmd
// result  | out_tvalid/out_tready/out_tdata| pos_x, pos_y, vel_x, vel_y
// config  | cfg_we/cfg_addr/cfg_wdata      | mass (index 0), drag (index 1)
//
// One beat is worked on at a time; in_tready is high only while the sequencer is idle.
// Every division runs on one shared radix-2 divider; products come from the shared
// 33x33 multiplier. Add force uses two divisions (plus the two velocity divisions
// once a step has run), a step eight, set position and the unused command only the
// two velocity divisions, and none before the first step. The result sits in an
// output register, so a new beat is taken while it waits; the sequencer stalls only
// when a second result is ready first.
// Reset (rst_n, synchronous) clears the point state, the sequencer and out_tvalid.
module verlet_point_integrator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: force_x[31:0], force_y[63:32], new_x[95:64], new_y[127:96],
  //           time_step[143:128]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vpi_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [vpi_pkg::CMD_W-1:0]      in_tuser,
  // out_tdata: pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [vpi_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [vpi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vpi_pkg::DATA_W-1:0]     cfg_wdata
);
  import vpi_pkg::*;

  state_t                   state_r, state_nxt;
  logic                     pend_r, pend_nxt;
  logic                     ax_r;

  logic [DATA_W-1:0]        mass_r;
  logic [DRAG_W-1:0]        drag_r;

  logic signed [DATA_W-1:0] cur_r  [2];
  logic signed [DATA_W-1:0] prev_r [2];
  logic signed [DATA_W-1:0] acc_r  [2];
  logic signed [DATA_W-1:0] nx_r   [2];
  logic signed [DATA_W-1:0] ov_r   [2];
  logic signed [DATA_W-1:0] frc_r  [2];
  logic signed [DATA_W-1:0] v_r;
  logic signed [DATA_W-1:0] fd_r;
  logic signed [DIV_W-1:0]  inert_r;
  logic [DT_W-1:0]          dt_r;
  logic [DT_W-1:0]          lt_r;
  logic [DT_W-1:0]          last_r;
  logic [DATA_W-1:0]        dt2_r;

  logic                     out_tvalid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  mul_req_t                 mul_req;
  logic [PROD_W-1:0]        prod_raw;

  logic signed [PROD_W-1:0] prod;
  logic signed [DIV_W-1:0]  div_q;
  logic signed [MUL_W-1:0]  diff;
  logic                     in_acc;
  cmd_t                     cmd;
  logic [DT_W-1:0]          ts;
  logic [DT_W-1:0]          dt_eff;

  assign prod   = $signed(prod_raw);
  assign div_q  = $signed(div_rsp.q);
  assign diff   = MUL_W'(cur_r[ax_r]) - MUL_W'(prev_r[ax_r]);
  assign in_acc = in_tvalid && in_tready;
  assign cmd    = cmd_t'(in_tuser);
  assign ts     = in_tdata[4*DATA_W +: DT_W];
  assign dt_eff = (ts == '0) ? DT_W'(1) : ts;

  vpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vpi_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod_raw)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= MASS_RST;
      drag_r <= DRAG_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MASS: mass_r <= cfg_wdata;
        REG_DRAG: drag_r <= cfg_wdata[DRAG_W-1:0];
        default:  mass_r <= mass_r;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Next state and requests to the shared units
  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    div_req     = '0;
    mul_req     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (cmd)
            CMD_FORCE: state_nxt = ST_FORCE;
            CMD_STEP:  state_nxt = ST_DT2;
            default:   state_nxt = ST_OVEL;
          endcase
        end
      end
      ST_FORCE: begin
        div_req.num = DIV_W'($signed({frc_r[ax_r], 16'b0}));
        div_req.den = mass_r;
        if (!pend_r) begin
          div_req.start = 1'b1;
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          pend_nxt = 1'b0;
          if (ax_r) begin
            state_nxt = ST_OVEL;
          end
        end
      end
      ST_DT2: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(dt_r);
        mul_req.b  = MUL_W'(dt_r);
        state_nxt  = ST_DT2W;
      end
      ST_DT2W: begin
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        div_req.num = DIV_W'($signed({diff, 16'b0}));
        div_req.den = DEN_W'(lt_r);
        if (!pend_r) begin
          div_req.start = 1'b1;
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_DMUL;
        end
      end
      ST_DMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(drag_r);
        mul_req.b  = MUL_W'(v_r);
        state_nxt  = ST_DFRC;
      end
      ST_DFRC: begin
        state_nxt = ST_DDIV;
      end
      ST_DDIV: begin
        div_req.num = DIV_W'($signed({fd_r, 16'b0}));
        div_req.den = mass_r;
        if (!pend_r) begin
          div_req.start = 1'b1;
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_IMUL;
        end
      end
      ST_IMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = diff;
        mul_req.b  = MUL_W'(dt_r);
        state_nxt  = ST_IDIV;
      end
      ST_IDIV: begin
        div_req.num = prod[DIV_W-1:0];
        div_req.den = DEN_W'(lt_r);
        if (!pend_r) begin
          div_req.start = 1'b1;
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_AMUL;
        end
      end
      ST_AMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(acc_r[ax_r]);
        mul_req.b  = MUL_W'(dt2_r);
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ax_r ? ST_COMMIT : ST_VEL;
      end
      ST_COMMIT: begin
        state_nxt = ST_OVEL;
      end
      ST_OVEL: begin
        div_req.num = DIV_W'($signed({diff, 16'b0}));
        div_req.den = DEN_W'(last_r);
        if (!pend_r) begin
          if (last_r == '0) begin
            if (ax_r) begin
              state_nxt = ST_OUT;
            end
          end else begin
            div_req.start = 1'b1;
            pend_nxt      = 1'b1;
          end
        end else if (div_rsp.done) begin
          pend_nxt = 1'b0;
          if (ax_r) begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  // Point state: position, previous position, last step, acceleration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r[0]  <= '0;
      cur_r[1]  <= '0;
      prev_r[0] <= '0;
      prev_r[1] <= '0;
      acc_r[0]  <= '0;
      acc_r[1]  <= '0;
      last_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc && cmd == CMD_SETPOS) begin
            cur_r[0]  <= in_tdata[2*DATA_W +: DATA_W];
            prev_r[0] <= in_tdata[2*DATA_W +: DATA_W];
            cur_r[1]  <= in_tdata[3*DATA_W +: DATA_W];
            prev_r[1] <= in_tdata[3*DATA_W +: DATA_W];
          end
        end
        ST_FORCE, ST_DDIV: begin
          if (pend_r && div_rsp.done) begin
            acc_r[ax_r] <= sat32(PROD_W'(acc_r[ax_r]) + PROD_W'(sat32(PROD_W'(div_q))));
          end
        end
        ST_COMMIT: begin
          prev_r[0] <= cur_r[0];
          prev_r[1] <= cur_r[1];
          cur_r[0]  <= nx_r[0];
          cur_r[1]  <= nx_r[1];
          acc_r[0]  <= '0;
          acc_r[1]  <= '0;
          last_r    <= dt_r;
        end
        default: begin
          last_r <= last_r;
        end
      endcase
    end
  end

  // Working values of one command
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ax_r <= 1'b0;
        if (in_acc) begin
          frc_r[0] <= in_tdata[0 +: DATA_W];
          frc_r[1] <= in_tdata[DATA_W +: DATA_W];
          dt_r     <= dt_eff;
          lt_r     <= (last_r == '0) ? dt_eff : last_r;
        end
      end
      ST_FORCE: begin
        if (pend_r && div_rsp.done) begin
          ax_r <= ~ax_r;
        end
      end
      ST_DT2W: begin
        dt2_r <= prod[DATA_W-1:0];
      end
      ST_VEL: begin
        if (pend_r && div_rsp.done) begin
          v_r <= sat32(PROD_W'(div_q));
        end
      end
      ST_DFRC: begin
        fd_r <= sat32(-trunc_shr(prod, 16));
      end
      ST_IDIV: begin
        if (pend_r && div_rsp.done) begin
          inert_r <= div_q;
        end
      end
      ST_SUM: begin
        nx_r[ax_r] <= sat32(PROD_W'(cur_r[ax_r]) + PROD_W'(inert_r) + trunc_shr(prod, 32));
        ax_r       <= ~ax_r;
      end
      ST_COMMIT: begin
        ax_r <= 1'b0;
      end
      ST_OVEL: begin
        if (!pend_r && last_r == '0) begin
          ov_r[ax_r] <= '0;
          ax_r       <= ~ax_r;
        end else if (pend_r && div_rsp.done) begin
          ov_r[ax_r] <= sat32(PROD_W'(div_q));
          ax_r       <= ~ax_r;
        end
      end
      default: begin
        ax_r <= ax_r;
      end
    endcase
  end

  // Output register: load when free or being taken, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_data_r <= {ov_r[1], ov_r[0], cur_r[1], cur_r[0]};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // The divider is only started when it is free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // An accepted beat closes the input until the result is loaded
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while a command is in progress");

  // A step leaves no acceleration behind
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMMIT |=> (acc_r[0] == '0 && acc_r[1] == '0))
    else $error("acceleration not cleared by step");

  // Leaving the result state always presents a beat
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && state_nxt == ST_IDLE) |=> out_tvalid)
    else $error("result not presented");

endmodule
